FILE: src/smm_pkg.sv
// shared widths, constants, codes and beat side structs for the svpwm injection core
`default_nettype none
package smm_pkg;

    // field and register widths
    localparam int VOLT_W     = 24;
    localparam int BUS_W      = 23;
    localparam int PER_W      = 16;
    localparam int MLIM_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int FAULT_W    = 2;
    localparam int SECTOR_W   = 3;

    // arithmetic unit sizes
    localparam int SQ_IN_W    = 64;
    localparam int SQ_OUT_W   = SQ_IN_W / 2;
    localparam int RS_Q_W     = 24;
    localparam int RS_DEN_W   = 32;
    localparam int CMP_Q_W    = 18;
    localparam int CMP_DEN_W  = 40;

    // fixed point constants
    localparam logic [23:0] INV_SQRT3_Q24  = 24'd9686330;
    localparam logic [15:0] HALF_SQRT3_Q16 = 16'd56756;
    localparam logic [MLIM_W-1:0] MLIM_ONE  = 16'd32768;
    localparam logic [MLIM_W-1:0] MLIM_RST  = 16'd31130;

    // sector codes
    localparam logic [SECTOR_W-1:0] SECTOR_NONE = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_1    = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_2    = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_3    = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_4    = 3'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_5    = 3'd5;
    localparam logic [SECTOR_W-1:0] SECTOR_6    = 3'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUS    = 2'd0,
        REG_PERIOD = 2'd1,
        REG_MLIM   = 2'd2
    } reg_index_t;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_OK      = 2'd0,
        FAULT_BUS     = 2'd1,
        FAULT_CFG     = 2'd2,
        FAULT_NUMERIC = 2'd3
    } fault_t;

    // travels beside the square root
    typedef struct packed {
        logic                     clamp;
        logic signed [VOLT_W-1:0] a;
        logic signed [VOLT_W-1:0] b;
        logic [47:0]              pa;
        logic [47:0]              pb;
        fault_t                   fault;
    } sq_side_t;

    // travels beside the rescale divider
    typedef struct packed {
        logic                     clamp;
        logic signed [VOLT_W-1:0] a;
        logic signed [VOLT_W-1:0] b;
        fault_t                   fault;
    } rs_side_t;

    // travels beside the compare divider
    typedef struct packed {
        logic [2:0]          npos;
        logic [SECTOR_W-1:0] sector;
        fault_t              fault;
    } cmp_side_t;

endpackage
`default_nettype wire

FILE: src/smm_if.sv
// valid/ready channel interfaces for voltage vectors and compare results
`default_nettype none
interface smm_vec_if;
    import smm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [VOLT_W-1:0] volt_alpha;
    logic signed [VOLT_W-1:0] volt_beta;
    modport source (output valid, volt_alpha, volt_beta, input ready);
    modport sink   (input valid, volt_alpha, volt_beta, output ready);
endinterface

interface smm_cmp_if;
    import smm_pkg::*;
    logic                valid;
    logic                ready;
    logic [PER_W-1:0]    compare_a;
    logic [PER_W-1:0]    compare_b;
    logic [PER_W-1:0]    compare_c;
    logic [FAULT_W-1:0]  fault_code;
    logic [SECTOR_W-1:0] sector;
    modport source (output valid, compare_a, compare_b, compare_c, fault_code, sector,
                    input ready);
    modport sink   (input valid, compare_a, compare_b, compare_c, fault_code, sector,
                    output ready);
endinterface
`default_nettype wire

FILE: src/svpwm_min_max_injection_core.sv
// svpwm core: vector clamp, inverse clarke, min-max injection and compare scaling
// throughput: one vector per cycle; a stalled output holds the whole pipeline in place
// depth is set by the 32 stage square root and the 24 and 18 stage dividers
// reset: pipeline empty, bus_voltage 0, pwm_period 0, modulation_limit 31130
`default_nettype none
module svpwm_min_max_injection_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [smm_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [smm_pkg::CFG_DATA_W-1:0] wr_data,
    smm_vec_if.sink                             volt,
    smm_cmp_if.source                           duty
);
    import smm_pkg::*;

    logic en;

    // configuration
    logic [BUS_W-1:0]  bus_reg;
    logic [PER_W-1:0]  per_reg;
    logic [MLIM_W-1:0] mlim_reg;
    logic [MLIM_W-1:0] mlim_sat;

    // front stages
    logic [4:0]               fv_reg;
    logic signed [VOLT_W-1:0] s0_a_reg, s1_a_reg, s2_a_reg, s3_a_reg, s4_a_reg;
    logic signed [VOLT_W-1:0] s0_b_reg, s1_b_reg, s2_b_reg, s3_b_reg, s4_b_reg;
    fault_t                   s0_fault_reg, s1_fault_reg, s2_fault_reg, s3_fault_reg;
    fault_t                   s4_fault_reg;
    logic [46:0]              s1_aa_reg, s1_bb_reg;
    logic [38:0]              s1_p_reg;
    logic [47:0]              s2_mag2_reg, s3_mag2_reg, s4_mag2_reg;
    logic [46:0]              s2_phi_reg;
    logic [39:0]              s2_plo_reg;
    logic [VOLT_W-1:0]        s3_vmax_reg;
    logic [47:0]              s4_vsq_reg, s4_pa_reg, s4_pb_reg;

    fault_t                   s0_fault_next, s3_fault_next;
    logic signed [47:0]       aa_next, bb_next;
    logic [62:0]              vsum_next;
    logic [VOLT_W-1:0]        a_abs, b_abs;

    // square root unit
    sq_side_t               sq_side_in, sq_side_out;
    logic [$bits(sq_side_t)-1:0] sq_side_vec;
    logic                   sq_vld;
    logic [SQ_OUT_W-1:0]    sq_root;

    // rescale
    logic                   s5_vld_reg;
    logic [RS_DEN_W+RS_Q_W-1:0] s5_num_reg [2];
    logic [RS_DEN_W-1:0]    s5_den_reg;
    rs_side_t               s5_side_reg, rs_side_out;
    logic [$bits(rs_side_t)-1:0] rs_side_vec;
    logic                   rs_vld;
    logic [RS_Q_W-1:0]      rs_q [2];

    // back stages
    logic [8:0]               bv_reg;
    logic signed [VOLT_W-1:0] s6_a_reg, s6_b_reg, s7_a_reg, s7_b_reg;
    logic signed [VOLT_W-1:0] a2_next, b2_next;
    fault_t                   s6_fault_reg, s7_fault_reg, s8_fault_reg, s9_fault_reg;
    fault_t                   s10_fault_reg, s11_fault_reg, s12_fault_reg;
    fault_t                   s13_fault_reg, s14_fault_reg;
    logic signed [40:0]       s7_sb_reg;
    logic signed [48:0]       s7_bk_reg;
    logic signed [41:0]       s8_v_reg [3];
    logic signed [41:0]       s9_v_reg [3];
    logic signed [41:0]       s10_v_reg [3];
    logic signed [41:0]       s9_hi_reg, s9_lo_reg;
    logic signed [42:0]       s10_sum_reg;
    logic signed [44:0]       s11_ph_reg [3];
    logic signed [61:0]       s12_pp_reg [3];
    logic [38:0]              s12_pbus_reg;
    logic signed [62:0]       s13_num_reg [3];
    logic [SECTOR_W-1:0]      s8_sec_reg, s9_sec_reg, s10_sec_reg, s11_sec_reg;
    logic [SECTOR_W-1:0]      s12_sec_reg, s13_sec_reg;
    logic [SECTOR_W-1:0]      sec_next;
    logic signed [41:0]       v_next [3];
    logic signed [41:0]       hi_next, lo_next;
    logic signed [49:0]       bk_ext, as_ext;

    // compare divider
    logic [CMP_DEN_W+CMP_Q_W-1:0] s14_num_reg [3];
    cmp_side_t              s14_side_reg, cmp_side_out;
    logic [$bits(cmp_side_t)-1:0] cmp_side_vec;
    logic                   cmp_vld;
    logic [CMP_Q_W-1:0]     cmp_q [3];
    logic signed [62:0]     nfull_next [3];

    // output register
    logic                   out_vld_reg;
    logic [PER_W-1:0]       out_cmp_reg [3];
    fault_t                 out_fault_reg;
    logic [SECTOR_W-1:0]    out_sec_reg;
    logic [PER_W-1:0]       cmp_next [3];

    assign en         = !out_vld_reg || duty.ready;
    assign volt.ready = en;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg  <= '0;
            per_reg  <= '0;
            mlim_reg <= MLIM_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_BUS:    bus_reg  <= wr_data[BUS_W-1:0];
                REG_PERIOD: per_reg  <= wr_data[PER_W-1:0];
                REG_MLIM:   mlim_reg <= wr_data[MLIM_W-1:0];
                default:    ;
            endcase
        end
    end

    assign mlim_sat = (mlim_reg > MLIM_ONE) ? MLIM_ONE : mlim_reg;

    // front end arithmetic: faults, magnitude squared, limit voltage
    always_comb
    begin
        if (bus_reg == '0)
            s0_fault_next = FAULT_BUS;
        else if (per_reg == '0 || mlim_sat == '0)
            s0_fault_next = FAULT_CFG;
        else
            s0_fault_next = FAULT_OK;
        aa_next   = s0_a_reg * s0_a_reg;
        bb_next   = s0_b_reg * s0_b_reg;
        vsum_next = {s2_phi_reg, 16'd0} + 63'(s2_plo_reg) + (63'd1 << 38);
        s3_fault_next = s2_fault_reg;
        if (s2_fault_reg == FAULT_OK && vsum_next[62:39] == '0)
            s3_fault_next = FAULT_CFG;
        a_abs = s3_a_reg[VOLT_W-1] ? (~s3_a_reg + 24'd1) : s3_a_reg;
        b_abs = s3_b_reg[VOLT_W-1] ? (~s3_b_reg + 24'd1) : s3_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else if (en)
            fv_reg <= {fv_reg[3:0], volt.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_a_reg     <= volt.volt_alpha;
            s0_b_reg     <= volt.volt_beta;
            s0_fault_reg <= s0_fault_next;
            s1_a_reg     <= s0_a_reg;
            s1_b_reg     <= s0_b_reg;
            s1_fault_reg <= s0_fault_reg;
            s1_aa_reg    <= aa_next[46:0];
            s1_bb_reg    <= bb_next[46:0];
            s1_p_reg     <= bus_reg * mlim_sat;
            s2_a_reg     <= s1_a_reg;
            s2_b_reg     <= s1_b_reg;
            s2_fault_reg <= s1_fault_reg;
            s2_mag2_reg  <= 48'(s1_aa_reg) + 48'(s1_bb_reg);
            s2_phi_reg   <= s1_p_reg[38:16] * INV_SQRT3_Q24;
            s2_plo_reg   <= s1_p_reg[15:0] * INV_SQRT3_Q24;
            s3_a_reg     <= s2_a_reg;
            s3_b_reg     <= s2_b_reg;
            s3_fault_reg <= s3_fault_next;
            s3_mag2_reg  <= s2_mag2_reg;
            s3_vmax_reg  <= vsum_next[62:39];
            s4_a_reg     <= s3_a_reg;
            s4_b_reg     <= s3_b_reg;
            s4_fault_reg <= s3_fault_reg;
            s4_mag2_reg  <= s3_mag2_reg;
            s4_vsq_reg   <= s3_vmax_reg * s3_vmax_reg;
            s4_pa_reg    <= a_abs * s3_vmax_reg;
            s4_pb_reg    <= b_abs * s3_vmax_reg;
        end
    end

    // magnitude with eight extra bits
    always_comb
    begin
        sq_side_in.clamp = (s4_mag2_reg > s4_vsq_reg);
        sq_side_in.a     = s4_a_reg;
        sq_side_in.b     = s4_b_reg;
        sq_side_in.pa    = s4_pa_reg;
        sq_side_in.pb    = s4_pb_reg;
        sq_side_in.fault = s4_fault_reg;
    end

    smm_isqrt #(
        .IN_W   (SQ_IN_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (fv_reg[4]),
        .n_in     ({s4_mag2_reg, 16'd0}),
        .side_in  (sq_side_in),
        .vld_out  (sq_vld),
        .root_out (sq_root),
        .side_out (sq_side_vec)
    );
    assign sq_side_out = sq_side_t'(sq_side_vec);

    // rescale numerators with half divisor for rounding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (en)
            s5_vld_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_num_reg[0]     <= {sq_side_out.pa, 8'd0} + 56'(sq_root >> 1);
            s5_num_reg[1]     <= {sq_side_out.pb, 8'd0} + 56'(sq_root >> 1);
            s5_den_reg        <= sq_root;
            s5_side_reg.clamp <= sq_side_out.clamp;
            s5_side_reg.a     <= sq_side_out.a;
            s5_side_reg.b     <= sq_side_out.b;
            s5_side_reg.fault <= sq_side_out.fault;
        end
    end

    smm_div #(
        .LANES  (2),
        .DEN_W  (RS_DEN_W),
        .Q_W    (RS_Q_W),
        .SIDE_W ($bits(rs_side_t))
    ) u_rescale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (s5_vld_reg),
        .num_in   (s5_num_reg),
        .den_in   (s5_den_reg),
        .side_in  (s5_side_reg),
        .vld_out  (rs_vld),
        .q_out    (rs_q),
        .side_out (rs_side_vec)
    );
    assign rs_side_out = rs_side_t'(rs_side_vec);

    // back end arithmetic: clamp select, inverse clarke, sector, injection, compare numerator
    always_comb
    begin
        a2_next = rs_side_out.a;
        b2_next = rs_side_out.b;
        if (rs_side_out.clamp)
        begin
            a2_next = rs_side_out.a[VOLT_W-1] ? (~rs_q[0] + 24'd1) : rs_q[0];
            b2_next = rs_side_out.b[VOLT_W-1] ? (~rs_q[1] + 24'd1) : rs_q[1];
        end

        v_next[0] = 42'($signed({s7_a_reg, 16'd0}));
        v_next[1] = 42'(s7_sb_reg) - 42'($signed({s7_a_reg, 15'd0}));
        v_next[2] = -42'(s7_sb_reg) - 42'($signed({s7_a_reg, 15'd0}));

        bk_ext = 50'(s7_bk_reg);
        as_ext = 50'($signed({s7_a_reg, 24'd0}));
        if (!s7_b_reg[VOLT_W-1])
        begin
            if (!s7_a_reg[VOLT_W-1])
                sec_next = (bk_ext > as_ext) ? SECTOR_2 : SECTOR_1;
            else
                sec_next = (bk_ext > -as_ext) ? SECTOR_2 : SECTOR_3;
        end
        else
        begin
            if (s7_a_reg[VOLT_W-1])
                sec_next = (-bk_ext > -as_ext) ? SECTOR_5 : SECTOR_4;
            else
                sec_next = (-bk_ext > as_ext) ? SECTOR_5 : SECTOR_6;
        end

        hi_next = s8_v_reg[0];
        lo_next = s8_v_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (s8_v_reg[i] > hi_next)
                hi_next = s8_v_reg[i];
            if (s8_v_reg[i] < lo_next)
                lo_next = s8_v_reg[i];
        end

        for (int i = 0; i < 3; i++)
            nfull_next[i] = s13_num_reg[i] + 63'($signed({1'b0, bus_reg, 16'd0}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bv_reg <= '0;
        else if (en)
            bv_reg <= {bv_reg[7:0], rs_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_a_reg      <= a2_next;
            s6_b_reg      <= b2_next;
            s6_fault_reg  <= rs_side_out.fault;
            s7_a_reg      <= s6_a_reg;
            s7_b_reg      <= s6_b_reg;
            s7_fault_reg  <= s6_fault_reg;
            s7_sb_reg     <= s6_b_reg * $signed({1'b0, HALF_SQRT3_Q16});
            s7_bk_reg     <= s6_b_reg * $signed({1'b0, INV_SQRT3_Q24});
            s8_fault_reg  <= s7_fault_reg;
            s8_sec_reg    <= sec_next;
            s9_fault_reg  <= s8_fault_reg;
            s9_sec_reg    <= s8_sec_reg;
            s9_hi_reg     <= hi_next;
            s9_lo_reg     <= lo_next;
            s10_fault_reg <= s9_fault_reg;
            s10_sec_reg   <= s9_sec_reg;
            s10_sum_reg   <= 43'(s9_hi_reg) + 43'(s9_lo_reg);
            s11_fault_reg <= s10_fault_reg;
            s11_sec_reg   <= s10_sec_reg;
            s12_fault_reg <= s11_fault_reg;
            s12_sec_reg   <= s11_sec_reg;
            s12_pbus_reg  <= per_reg * bus_reg;
            s13_fault_reg <= s12_fault_reg;
            s13_sec_reg   <= s12_sec_reg;
            s14_fault_reg <= s13_fault_reg;
            for (int i = 0; i < 3; i++)
            begin
                s8_v_reg[i]    <= v_next[i];
                s9_v_reg[i]    <= s8_v_reg[i];
                s10_v_reg[i]   <= s9_v_reg[i];
                s11_ph_reg[i]  <= 45'($signed({s10_v_reg[i], 1'b0})) - 45'(s10_sum_reg);
                s12_pp_reg[i]  <= s11_ph_reg[i] * $signed({1'b0, per_reg});
                s13_num_reg[i] <= 63'($signed({1'b0, s12_pbus_reg, 16'd0}))
                                  + 63'(s12_pp_reg[i]);
                s14_num_reg[i] <= nfull_next[i][CMP_DEN_W+CMP_Q_W-1:0];
                s14_side_reg.npos[i] <= !s13_num_reg[i][62] && (s13_num_reg[i] != '0);
            end
            s14_side_reg.sector <= s13_sec_reg;
            s14_side_reg.fault  <= s13_fault_reg;
        end
    end

    smm_div #(
        .LANES  (3),
        .DEN_W  (CMP_DEN_W),
        .Q_W    (CMP_Q_W),
        .SIDE_W ($bits(cmp_side_t))
    ) u_compare (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (bv_reg[8]),
        .num_in   (s14_num_reg),
        .den_in   ({bus_reg, 17'd0}),
        .side_in  (s14_side_reg),
        .vld_out  (cmp_vld),
        .q_out    (cmp_q),
        .side_out (cmp_side_vec)
    );
    assign cmp_side_out = cmp_side_t'(cmp_side_vec);

    // saturate compares, fault fallback to half period
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cmp_side_out.fault != FAULT_OK)
                cmp_next[i] = per_reg >> 1;
            else if (!cmp_side_out.npos[i])
                cmp_next[i] = '0;
            else if (cmp_q[i] > CMP_Q_W'(per_reg))
                cmp_next[i] = per_reg;
            else
                cmp_next[i] = cmp_q[i][PER_W-1:0];
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= cmp_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                out_cmp_reg[i] <= cmp_next[i];
            out_fault_reg <= cmp_side_out.fault;
            out_sec_reg   <= (cmp_side_out.fault != FAULT_OK) ? SECTOR_NONE
                                                              : cmp_side_out.sector;
        end
    end

    assign duty.valid      = out_vld_reg;
    assign duty.compare_a  = out_cmp_reg[0];
    assign duty.compare_b  = out_cmp_reg[1];
    assign duty.compare_c  = out_cmp_reg[2];
    assign duty.fault_code = out_fault_reg;
    assign duty.sector     = out_sec_reg;
endmodule
`default_nettype wire

FILE: src/smm_isqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none
module smm_isqrt #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                vld_in,
    input  wire logic [IN_W-1:0]     n_in,
    input  wire logic [SIDE_W-1:0]   side_in,
    output logic                     vld_out,
    output logic [IN_W/2-1:0]        root_out,
    output logic [SIDE_W-1:0]        side_out
);
    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 3;

    logic [OUT_W-1:0]  vld_reg;
    logic [IN_W-1:0]   n_reg    [OUT_W-1];
    logic [RW-1:0]     rem_reg  [OUT_W-1];
    logic [OUT_W-1:0]  root_reg [OUT_W];
    logic [SIDE_W-1:0] side_reg [OUT_W];

    logic [IN_W-1:0]   src_n    [OUT_W];
    logic [RW-1:0]     src_rem  [OUT_W];
    logic [OUT_W-1:0]  src_root [OUT_W];
    logic [IN_W-1:0]   n_next    [OUT_W];
    logic [RW-1:0]     rem_next  [OUT_W];
    logic [OUT_W-1:0]  root_next [OUT_W];

    // one digit step per stage: bring down two bits, try root*4+1
    always_comb
    begin
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          ge;
        src_n[0]    = n_in;
        src_rem[0]  = '0;
        src_root[0] = '0;
        for (int k = 1; k < OUT_W; k++)
        begin
            src_n[k]    = n_reg[k-1];
            src_rem[k]  = rem_reg[k-1];
            src_root[k] = root_reg[k-1];
        end
        for (int k = 0; k < OUT_W; k++)
        begin
            rem_sh       = {src_rem[k][RW-3:0], src_n[k][IN_W-1:IN_W-2]};
            trial        = {1'b0, src_root[k], 2'b01};
            ge           = (rem_sh >= trial);
            rem_next[k]  = ge ? (rem_sh - trial) : rem_sh;
            root_next[k] = {src_root[k][OUT_W-2:0], ge};
            n_next[k]    = {src_n[k][IN_W-3:0], 2'b00};
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[OUT_W-2:0], vld_in};
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < OUT_W; k++)
                side_reg[k] <= side_reg[k-1];
            for (int k = 0; k < OUT_W; k++)
                root_reg[k] <= root_next[k];
            for (int k = 0; k < OUT_W - 1; k++)
            begin
                n_reg[k]   <= n_next[k];
                rem_reg[k] <= rem_next[k];
            end
        end
    end

    assign vld_out  = vld_reg[OUT_W-1];
    assign root_out = root_reg[OUT_W-1];
    assign side_out = side_reg[OUT_W-1];
endmodule
`default_nettype wire

FILE: src/smm_div.sv
// pipelined restoring divider, one quotient bit per stage, lanes share the divisor
`default_nettype none
module smm_div #(
    parameter int LANES  = 1,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 24,
    parameter int SIDE_W = 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   vld_in,
    input  wire logic [DEN_W+Q_W-1:0]   num_in [LANES],
    input  wire logic [DEN_W-1:0]       den_in,
    input  wire logic [SIDE_W-1:0]      side_in,
    output logic                        vld_out,
    output logic [Q_W-1:0]              q_out [LANES],
    output logic [SIDE_W-1:0]           side_out
);
    localparam int NUM_W = DEN_W + Q_W;

    logic [Q_W-1:0]    vld_reg;
    logic [DEN_W-1:0]  den_reg  [Q_W-1];
    logic [DEN_W-1:0]  rem_reg  [Q_W-1][LANES];
    logic [Q_W-1:0]    sq_reg   [Q_W][LANES];
    logic [SIDE_W-1:0] side_reg [Q_W];

    logic [DEN_W-1:0]  src_den  [Q_W];
    logic [DEN_W-1:0]  src_rem  [Q_W][LANES];
    logic [Q_W-1:0]    src_sq   [Q_W][LANES];
    logic [DEN_W-1:0]  rem_next [Q_W][LANES];
    logic [Q_W-1:0]    sq_next  [Q_W][LANES];

    // shift one dividend bit in, subtract when it fits; quotient bits fill from below
    always_comb
    begin
        logic [DEN_W:0] rem_sh;
        logic           ge;
        src_den[0] = den_in;
        for (int l = 0; l < LANES; l++)
        begin
            src_rem[0][l] = num_in[l][NUM_W-1:Q_W];
            src_sq[0][l]  = num_in[l][Q_W-1:0];
        end
        for (int k = 1; k < Q_W; k++)
        begin
            src_den[k] = den_reg[k-1];
            for (int l = 0; l < LANES; l++)
            begin
                src_rem[k][l] = rem_reg[k-1][l];
                src_sq[k][l]  = sq_reg[k-1][l];
            end
        end
        for (int k = 0; k < Q_W; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_sh = {src_rem[k][l], src_sq[k][l][Q_W-1]};
                ge     = (rem_sh >= {1'b0, src_den[k]});
                rem_next[k][l] = ge ? DEN_W'(rem_sh - {1'b0, src_den[k]})
                                    : rem_sh[DEN_W-1:0];
                sq_next[k][l]  = {src_sq[k][l][Q_W-2:0], ge};
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Q_W-2:0], vld_in};
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < Q_W; k++)
                side_reg[k] <= side_reg[k-1];
            for (int k = 0; k < Q_W; k++)
                for (int l = 0; l < LANES; l++)
                    sq_reg[k][l] <= sq_next[k][l];
            for (int k = 0; k < Q_W - 1; k++)
            begin
                den_reg[k] <= src_den[k];
                for (int l = 0; l < LANES; l++)
                    rem_reg[k][l] <= rem_next[k][l];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            q_out[l] = sq_reg[Q_W-1][l];
    end
    assign vld_out  = vld_reg[Q_W-1];
    assign side_out = side_reg[Q_W-1];
endmodule
`default_nettype wire

FILE: tb/svpwm_min_max_injection_core_test.sv
// self-checking testbench for the svpwm min-max injection core
`timescale 1ns / 1ps
`default_nettype none
module svpwm_min_max_injection_core_test;
    import smm_pkg::*;

    localparam int               IDLE_LIMIT = 4000;
    localparam int               DRAIN_WAIT = 120;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic signed [VOLT_W-1:0] VPOS = 24'sd8388607;
    localparam logic signed [VOLT_W-1:0] VNEG = -24'sd8388608;

    typedef struct {
        logic [PER_W-1:0]    ca;
        logic [PER_W-1:0]    cb;
        logic [PER_W-1:0]    cc;
        fault_t              fault;
        logic [SECTOR_W-1:0] sector;
    } duty_t;

    typedef struct {
        logic                     cfg;
        longint unsigned          bus;
        longint unsigned          per;
        longint unsigned          mlim;
        logic signed [VOLT_W-1:0] al;
        logic signed [VOLT_W-1:0] be;
        logic                     typed;
        duty_t                    want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;

    smm_vec_if volt ();
    smm_cmp_if duty ();

    svpwm_min_max_injection_core uut (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .volt(volt), .duty(duty)
    );

    always #5 clk = ~clk;

    // shadow copy of the registers
    longint unsigned bus_reg = 0;
    longint unsigned per_reg = 0;
    longint unsigned mlim_reg = 31130;

    duty_t duty_pending[$];
    int    fails = 0;
    int    idle_cycles = 0;
    bit    quiet = 0;
    int    stall_left = 0;

    function automatic longint rescale_axis(longint x, longint unsigned vmax,
                                            longint unsigned mag);
        longint unsigned ax;
        longint unsigned q;
        ax = (x < 0) ? -x : x;
        q = (ax * vmax * 256 + mag / 2) / mag;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [PER_W-1:0] phase_compare(longint ph);
        longint num;
        longint den;
        longint q;
        num = longint'(per_reg) * longint'(bus_reg) * 65536 + longint'(per_reg) * ph;
        den = longint'(bus_reg) * 131072;
        if (num <= 0) return '0;
        q = (num + den / 2) / den;
        if (q > longint'(per_reg)) q = longint'(per_reg);
        return q[PER_W-1:0];
    endfunction

    // expected compares, fault and sector for one vector under the current registers
    function automatic duty_t compute_duty(logic signed [VOLT_W-1:0] al,
                                           logic signed [VOLT_W-1:0] be);
        longint a, b, ha, sb, pa, pb, pc, hi, lo, sum, bk, as_q;
        longint unsigned mlim, vmax, mag2, n, r, bitv;
        duty_t res;
        a = al;
        b = be;
        mlim = (mlim_reg > 32768) ? 32768 : mlim_reg;
        res.fault = FAULT_OK;
        vmax = 0;
        if (bus_reg == 0) res.fault = FAULT_BUS;
        else if (per_reg == 0 || mlim == 0) res.fault = FAULT_CFG;
        else
        begin
            vmax = (bus_reg * mlim * 64'd9686330 + (64'd1 << 38)) >> 39;
            if (vmax == 0) res.fault = FAULT_CFG;
        end
        if (res.fault != FAULT_OK)
        begin
            res.ca = PER_W'(per_reg / 2);
            res.cb = PER_W'(per_reg / 2);
            res.cc = PER_W'(per_reg / 2);
            res.sector = SECTOR_NONE;
            return res;
        end
        // clamp the magnitude, keep the direction
        mag2 = longint'(a * a) + longint'(b * b);
        if (mag2 > vmax * vmax)
        begin
            n = mag2 << 16;
            r = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= r + bitv)
                begin
                    n = n - (r + bitv);
                    r = (r >> 1) + bitv;
                end
                else r = r >> 1;
                bitv = bitv >> 2;
            end
            a = rescale_axis(a, vmax, r);
            b = rescale_axis(b, vmax, r);
        end
        // inverse clarke and min-max injection
        ha = a * 32768;
        sb = b * 56756;
        pa = a * 65536;
        pb = -ha + sb;
        pc = -ha - sb;
        hi = pa;
        lo = pa;
        if (pb > hi) hi = pb;
        if (pc > hi) hi = pc;
        if (pb < lo) lo = pb;
        if (pc < lo) lo = pc;
        sum = hi + lo;
        res.ca = phase_compare(2 * pa - sum);
        res.cb = phase_compare(2 * pb - sum);
        res.cc = phase_compare(2 * pc - sum);
        // coarse sector
        bk = b * 9686330;
        as_q = a * 16777216;
        if (b >= 0)
        begin
            if (a >= 0) res.sector = (bk > as_q) ? SECTOR_2 : SECTOR_1;
            else res.sector = (bk > -as_q) ? SECTOR_2 : SECTOR_3;
        end
        else
        begin
            if (a < 0) res.sector = (-bk > -as_q) ? SECTOR_5 : SECTOR_4;
            else res.sector = (-bk > as_q) ? SECTOR_5 : SECTOR_6;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // wait for the pipeline to drain, then write the unused index and all registers in one burst
    task automatic load_regs(longint unsigned bus, longint unsigned per,
                             longint unsigned mlim);
        while (duty_pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= REG_UNUSED;
        wr_data <= CFG_DATA_W'($urandom);
        @(posedge clk);
        wr_index <= REG_BUS;
        wr_data <= CFG_DATA_W'(bus);
        @(posedge clk);
        wr_index <= REG_PERIOD;
        wr_data <= CFG_DATA_W'(per);
        @(posedge clk);
        wr_index <= REG_MLIM;
        wr_data <= CFG_DATA_W'(mlim);
        @(posedge clk);
        wr_en <= 1'b0;
        bus_reg = bus;
        per_reg = per;
        mlim_reg = mlim;
    endtask

    // drive one vector beat, queue its expected compares once accepted
    task automatic send_vec(logic signed [VOLT_W-1:0] al, logic signed [VOLT_W-1:0] be,
                            logic typed, duty_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            volt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        volt.valid <= 1'b1;
        volt.volt_alpha <= al;
        volt.volt_beta <= be;
        do @(posedge clk); while (!volt.ready);
        duty_pending.push_back(typed ? want : compute_duty(al, be));
    endtask

    // receiver with random stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            duty.ready <= 1'b0;
        end
        else
        begin
            duty.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 25)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
        end
        if ($urandom_range(0, 299) == 0) quiet <= ~quiet;
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        duty_t exp_d;
        if (duty.valid && duty.ready)
        begin
            if (duty_pending.size() == 0)
            begin
                $display("%0t unexpected result beat: a %0d b %0d c %0d fault %0d sector %0d",
                         $time, duty.compare_a, duty.compare_b, duty.compare_c,
                         duty.fault_code, duty.sector);
                fails++;
            end
            else
            begin
                exp_d = duty_pending.pop_front();
                if (duty.compare_a !== exp_d.ca)
                begin
                    $display("%0t compare_a expected %0d actual %0d", $time, exp_d.ca,
                             duty.compare_a);
                    fails++;
                end
                if (duty.compare_b !== exp_d.cb)
                begin
                    $display("%0t compare_b expected %0d actual %0d", $time, exp_d.cb,
                             duty.compare_b);
                    fails++;
                end
                if (duty.compare_c !== exp_d.cc)
                begin
                    $display("%0t compare_c expected %0d actual %0d", $time, exp_d.cc,
                             duty.compare_c);
                    fails++;
                end
                if (duty.fault_code !== exp_d.fault)
                begin
                    $display("%0t fault_code expected %0d actual %0d", $time, exp_d.fault,
                             duty.fault_code);
                    fails++;
                end
                if (duty.sector !== exp_d.sector)
                begin
                    $display("%0t sector expected %0d actual %0d", $time, exp_d.sector,
                             duty.sector);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((volt.valid && volt.ready) || (duty.valid && duty.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // directed rows, typed results only where obvious
    row_t directed[] = '{
        '{0, 0, 0, 0, 24'sd1000, 24'sd0, 1, '{16'd0, 16'd0, 16'd0, FAULT_BUS, SECTOR_NONE}},
        '{1, 409600, 0, 31130, 24'sd5, 24'sd7, 1,
          '{16'd0, 16'd0, 16'd0, FAULT_CFG, SECTOR_NONE}},
        '{1, 409600, 1000, 0, 24'sd5, 24'sd7, 1,
          '{16'd500, 16'd500, 16'd500, FAULT_CFG, SECTOR_NONE}},
        '{1, 1, 1000, 1, VPOS, VNEG, 1, '{16'd500, 16'd500, 16'd500, FAULT_CFG, SECTOR_NONE}},
        '{1, 409600, 1000, 32768, 24'sd0, 24'sd0, 1,
          '{16'd500, 16'd500, 16'd500, FAULT_OK, SECTOR_1}},
        '{0, 0, 0, 0, 24'sd1000, 24'sd0, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{0, 0, 0, 0, 24'sd1000, 24'sd1000, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{0, 0, 0, 0, 24'sd0, 24'sd1000, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{0, 0, 0, 0, -24'sd1000, 24'sd1000, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{0, 0, 0, 0, -24'sd1000, -24'sd10, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{0, 0, 0, 0, 24'sd0, -24'sd1000, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{0, 0, 0, 0, 24'sd1000, -24'sd1000, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{0, 0, 0, 0, VPOS, VPOS, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{0, 0, 0, 0, VNEG, VNEG, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{1, 8388607, 65535, 65535, VPOS, VNEG, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{0, 0, 0, 0, VNEG, VPOS, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{0, 0, 0, 0, 24'sd3000000, 24'sd100, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{1, 8388607, 65535, 32768, VPOS, 24'sd0, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{0, 0, 0, 0, -24'sd2000000, -24'sd3000000, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}},
        '{1, 100, 7, 1, 24'sd50, -24'sd80, 0, '{0, 0, 0, FAULT_OK, SECTOR_NONE}}
    };

    initial
    begin
        int lim, r;
        longint unsigned bus, per, mlim;
        logic signed [VOLT_W-1:0] al, be;
        duty_t none_d;
        none_d = '{0, 0, 0, FAULT_OK, SECTOR_NONE};
        volt.valid = 1'b0;
        volt.volt_alpha = '0;
        volt.volt_beta = '0;
        duty.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (directed[i])
        begin
            if (directed[i].cfg)
            begin
                volt.valid <= 1'b0;
                load_regs(directed[i].bus, directed[i].per, directed[i].mlim);
            end
            send_vec(directed[i].al, directed[i].be, directed[i].typed, directed[i].want);
        end

        // random phases, each with its own register setting
        for (int ph = 0; ph < 10; ph++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5) bus = 0;
            else if (r < 15) bus = 8388607;
            else if (r < 25) bus = $urandom_range(1, 200);
            else if (r < 60) bus = 4096 * $urandom_range(12, 60);
            else bus = $urandom_range(1, 8388607);
            r = $urandom_range(0, 99);
            if (r < 5) per = 0;
            else if (r < 20) per = 65535;
            else if (r < 30) per = $urandom_range(1, 10);
            else per = $urandom_range(1, 65535);
            r = $urandom_range(0, 99);
            if (r < 5) mlim = 0;
            else if (r < 20) mlim = 32768;
            else if (r < 30) mlim = $urandom_range(32769, 65535);
            else mlim = $urandom_range(1, 32768);
            if (ph == 9)
            begin
                bus = 8388607;
                per = 65535;
                mlim = 65535;
            end
            volt.valid <= 1'b0;
            load_regs(bus, per, mlim);
            lim = (bus > 8388607 / 2) ? 8388607 / 2 : int'(bus);
            for (int k = 0; k < 103; k++)
            begin
                if ($urandom_range(0, 99) < 65)
                begin
                    al = VOLT_W'(int'($urandom_range(0, 2 * lim)) - lim);
                    be = VOLT_W'(int'($urandom_range(0, 2 * lim)) - lim);
                end
                else
                begin
                    al = VOLT_W'($urandom);
                    be = VOLT_W'($urandom);
                end
                send_vec(al, be, 1'b0, none_d);
            end
        end
        volt.valid <= 1'b0;

        // drain, then let any stray beats show up
        while (duty_pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
